[sv/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Beat structs, controller states, command bundle, opcode and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEPTH_DEF          = 16;
  localparam int unsigned ID_WIDTH_DEF       = 16;
  localparam int unsigned PRIORITY_WIDTH_DEF = 16;

  // opcode field codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // status field codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic [15:0]        item_id;
    logic signed [15:0] priority_req;
  } spq_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               popped_valid;
    logic [15:0]        popped_id;
    logic signed [15:0] popped_priority;
    logic [4:0]         entry_count;
  } spq_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } spq_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the request beat
    logic execute;   // apply the operation and register the result
  } spq_cmd_t;

endpackage

[sv/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue: min-first priority queue on a sorted cell row
// Insert places an entry ahead of the first one of equal or greater
// priority; pop returns the head. Every operation answers with one beat.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload             Direction
//  request   start, busy           req_i  (spq_req_t)  in
//  result    done_o (strobe)       rsp_o  (spq_rsp_t)  out
//
// Each operation runs accept, execute in the cell row, then result
// beat, stepped by the 3-state sequencer; busy is high until the result
// beat has gone out, so the next request is taken in the cycle after done_o.
// The result beat lasts one cycle; the receiver cannot stall it.
// Reset clears the entry count and sequencer; the stored entries are not
// cleared, since the contents of unoccupied cells never reach a result.
module sorted_priority_queue #(
  parameter int unsigned DEPTH          = spq_pkg::DEPTH_DEF,
  parameter int unsigned ID_WIDTH       = spq_pkg::ID_WIDTH_DEF,
  parameter int unsigned PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::spq_req_t req_i,
  output logic              done_o,
  output spq_pkg::spq_rsp_t rsp_o
);

  spq_pkg::spq_cmd_t cmd;

  // sequencer: capture, execute, result strobe
  spq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // sorted store and result register
  spq_datapath #(
    .DEPTH          (DEPTH),
    .ID_WIDTH       (ID_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

[sv/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl: operation sequencer
// Takes a request, runs one execute cycle, then presents the result beat.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  output spq_pkg::spq_cmd_t cmd_o
);

  spq_pkg::spq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    busy          = 1'b1;
    done_o        = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      spq_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = spq_pkg::ST_EXEC;
        end
      end
      spq_pkg::ST_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = spq_pkg::ST_RESP;
      end
      spq_pkg::ST_RESP: begin
        done_o  = 1'b1;
        state_d = spq_pkg::ST_IDLE;
      end
      default: begin
        state_d = spq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[sv/spq_datapath.sv]
// ----------------------------------------------------------------------------
// spq_datapath: sorted shift-register store
// Row of cells in ascending priority; each cell compares and shifts locally.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int unsigned DEPTH          = spq_pkg::DEPTH_DEF,
  parameter int unsigned ID_WIDTH       = spq_pkg::ID_WIDTH_DEF,
  parameter int unsigned PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spq_pkg::spq_cmd_t cmd_i,
  input  spq_pkg::spq_req_t req_i,
  output spq_pkg::spq_rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  spq_pkg::spq_req_t req_q;
  spq_pkg::spq_rsp_t rsp_q, rsp_d;

  logic [ID_WIDTH-1:0]              id_q   [DEPTH];
  logic signed [PRIORITY_WIDTH-1:0] prio_q [DEPTH];
  logic [CW-1:0]                    count_q, count_d;

  logic [ID_WIDTH-1:0]              id_in;
  logic signed [PRIORITY_WIDTH-1:0] prio_in;
  logic [31:0]                      id_ext, prio_ext, head_prio_ext, count_ext;
  logic [DEPTH-1:0]                 ge;
  logic                             full, empty, do_ins, do_pop;

  // narrow or sign-extend the request fields to the stored widths
  assign id_ext   = 32'(req_q.item_id);
  assign prio_ext = {{16{req_q.priority_req[15]}}, req_q.priority_req};
  assign id_in    = id_ext[ID_WIDTH-1:0];
  assign prio_in  = prio_ext[PRIORITY_WIDTH-1:0];

  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);
  assign do_ins = cmd_i.execute && (req_q.opcode == spq_pkg::OP_INSERT) && !full;
  assign do_pop = cmd_i.execute && (req_q.opcode == spq_pkg::OP_POP) && !empty;

  // per-cell: occupied and priority not below the new one
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      ge[k] = (CW'(k) < count_q) && (prio_q[k] >= prio_in);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (do_ins) begin
      for (int k = 0; k < DEPTH; k++) begin
        if (k > 0 && ge[(k > 0) ? k - 1 : 0]) begin
          id_q[k]   <= id_q[(k > 0) ? k - 1 : 0];
          prio_q[k] <= prio_q[(k > 0) ? k - 1 : 0];
        end else if (ge[k] || CW'(k) == count_q) begin
          id_q[k]   <= id_in;
          prio_q[k] <= prio_in;
        end
      end
    end else if (do_pop) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        id_q[k]   <= id_q[k + 1];
        prio_q[k] <= prio_q[k + 1];
      end
    end
    if (cmd_i.execute) begin
      rsp_q <= rsp_d;
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CW'(1);
    end else if (do_pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_prio_ext = 32'(unsigned'(prio_q[0]));
  assign count_ext     = 32'(count_d);

  always_comb begin
    rsp_d                 = '0;
    rsp_d.entry_count     = count_ext[4:0];
    if (req_q.opcode == spq_pkg::OP_INSERT) begin
      rsp_d.status = full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
    end else if (empty) begin
      rsp_d.status = spq_pkg::ST_EMPTY;
    end else begin
      rsp_d.status          = spq_pkg::ST_DONE;
      rsp_d.popped_valid    = 1'b1;
      rsp_d.popped_id       = 16'(id_q[0]);
      rsp_d.popped_priority = head_prio_ext[15:0];
    end
  end

  assign rsp_o = rsp_q;

endmodule

[tb/spq_checker.sv]
// ----------------------------------------------------------------------------
// spq_checker: result prediction and comparison for sorted_priority_queue
// Keeps a shadow copy of the sorted store, works out the result of each
// accepted request beat and checks every result beat against it in order.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  spq_req_t    req_i,
  input  logic        done_i,
  input  spq_rsp_t    rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SlotCount = DEPTH_DEF;
  localparam int unsigned ReportMax = 10;

  // shadow store, head at index 0, ascending priority
  logic [15:0]        slot_ids   [SlotCount];
  logic signed [15:0] slot_prios [SlotCount];
  int unsigned        slot_fill;

  spq_rsp_t expected_rsp_q [$];

  // Applies one operation to the shadow store and returns its result beat.
  function automatic spq_rsp_t serve_request(input spq_req_t req);
    spq_rsp_t           rsp;
    logic signed [15:0] prio;
    int unsigned        pos;
    rsp  = '0;
    prio = req.priority_req;
    pos  = 0;
    if (req.opcode == OP_INSERT) begin
      if (slot_fill >= SlotCount) begin
        rsp.status = ST_FULL;
      end else begin
        // new entry goes ahead of every equal priority
        while (pos < slot_fill && slot_prios[pos] < prio) pos++;
        for (int unsigned k = slot_fill; k > pos; k--) begin
          slot_ids[k]   = slot_ids[k-1];
          slot_prios[k] = slot_prios[k-1];
        end
        slot_ids[pos]   = req.item_id;
        slot_prios[pos] = prio;
        slot_fill++;
        rsp.status = ST_DONE;
      end
    end else begin
      if (slot_fill == 0) begin
        rsp.status = ST_EMPTY;
      end else begin
        rsp.status          = ST_DONE;
        rsp.popped_valid    = 1'b1;
        rsp.popped_id       = slot_ids[0];
        rsp.popped_priority = slot_prios[0];
        for (int unsigned k = 1; k < slot_fill; k++) begin
          slot_ids[k-1]   = slot_ids[k];
          slot_prios[k-1] = slot_prios[k];
        end
        slot_fill--;
      end
    end
    rsp.entry_count = 5'(slot_fill);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    spq_rsp_t want;
    if (!rst_ni) begin
      slot_fill    = 0;
      fail_count_o = 0;
      pending_o    = 0;
      expected_rsp_q.delete();
    end else begin
      // results first: a result beat always belongs to an earlier request
      if (done_i) begin
        if (expected_rsp_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= ReportMax)
            $display("%t unexpected result beat st=%0d pv=%0d id=%h pr=%h cnt=%0d",
                     $realtime, rsp_i.status, rsp_i.popped_valid, rsp_i.popped_id,
                     rsp_i.popped_priority, rsp_i.entry_count);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_i.status !== want.status || rsp_i.popped_valid !== want.popped_valid ||
              rsp_i.popped_id !== want.popped_id ||
              rsp_i.popped_priority !== want.popped_priority ||
              rsp_i.entry_count !== want.entry_count) begin
            fail_count_o++;
            if (fail_count_o <= ReportMax)
              $display("%t mismatch exp st=%0d pv=%0d id=%h pr=%h cnt=%0d",
                       $realtime, want.status, want.popped_valid, want.popped_id,
                       want.popped_priority, want.entry_count,
                       " got st=%0d pv=%0d id=%h pr=%h cnt=%0d",
                       rsp_i.status, rsp_i.popped_valid, rsp_i.popped_id,
                       rsp_i.popped_priority, rsp_i.entry_count);
          end
        end
      end
      if (start_i && !busy_i) expected_rsp_q.push_back(serve_request(req_i));
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: top level for sorted_priority_queue verification
// Drives insert and pop request beats with random gaps; the checker beside
// the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int unsigned RandomOps  = 1350;
  localparam int unsigned QuietTail  = 200;   // last ops run back to back
  localparam int unsigned PhaseLen   = 40;    // ops per traffic phase
  localparam int unsigned StallLimit = 1000;  // cycles with no beat at all
  localparam int unsigned DrainWait  = 10;    // margin once nothing is pending

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  spq_req_t    req;
  logic        done;
  spq_rsp_t    rsp;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;

  always #2 clk = ~clk;

  sorted_priority_queue dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .rsp_o  (rsp)
  );

  spq_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .done_i       (done),
    .rsp_i        (rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Watchdog: any accepted beat on either channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("FAIL sorted_priority_queue");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic spq_req_t insert_beat(input logic [15:0] id, input logic [15:0] prio);
    spq_req_t r;
    r.opcode       = OP_INSERT;
    r.item_id      = id;
    r.priority_req = prio;
    return r;
  endfunction

  // Pop ignores id and priority; random junk there checks that.
  function automatic spq_req_t pop_beat();
    spq_req_t r;
    r.opcode       = OP_POP;
    r.item_id      = 16'($urandom);
    r.priority_req = 16'($urandom);
    return r;
  endfunction

  // Mix of priority shapes: a narrow band for ties, full range, the two
  // extremes, and whole Q8.8 values.
  function automatic logic [15:0] pick_priority();
    case ($urandom_range(0, 5))
      0, 1:    return 16'($urandom_range(0, 8)) - 16'd4;
      2:       return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
      3:       return {8'($urandom), 8'h00};
      default: return 16'($urandom);
    endcase
  endfunction

  // One request beat. The strobe is dropped only for an idle burst, so a
  // back-to-back beat keeps start high with a single assignment per step.
  // Returns at the edge that accepts the beat.
  task automatic issue(input spq_req_t r, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  initial begin : stimulus
    int unsigned insert_pct;
    bit          quiet;
    int unsigned gap;
    spq_req_t    r;

    rst_n = 1'b0;
    start = 1'b0;
    req   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: pop on empty, extreme ids and priorities, ties at the
    // head and in the middle, fill to the brim, insert on full, some pops.
    issue(pop_beat(), 0);
    issue(insert_beat(16'h0000, 16'h0000), 0);
    issue(insert_beat(16'hFFFF, 16'h0000), 0);   // tie at the head
    issue(insert_beat(16'h0001, 16'h7FFF), 0);   // largest priority
    issue(insert_beat(16'h0002, 16'h8000), 0);   // smallest priority
    issue(insert_beat(16'h0003, 16'h8000), 0);   // tie with the new head
    for (int unsigned i = 0; i < 11; i++)
      issue(insert_beat(16'h1000 + 16'(i), 16'h0100 * 16'(i % 4) - 16'h0100), 0);
    issue(insert_beat(16'hAAAA, 16'h0000), 0);   // store is full now
    for (int unsigned i = 0; i < 4; i++) issue(pop_beat(), 0);

    // Random part: phases that fill, drain or balance the store, so the
    // count sweeps empty to full; some phases run without idle cycles.
    insert_pct = 50;
    quiet      = 1'b0;
    for (int unsigned n = 0; n < RandomOps; n++) begin
      if (n % PhaseLen == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 15;
          default: insert_pct = 50;
        endcase
        quiet = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < insert_pct)
        r = insert_beat(16'($urandom), pick_priority());
      else
        r = pop_beat();
      gap = 0;
      if (!quiet && n < RandomOps - QuietTail && $urandom_range(0, 9) < 3)
        gap = $urandom_range(1, 7);
      issue(r, gap);
    end
    start <= 1'b0;

    // Wait out the outstanding results; the watchdog bounds this.
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS sorted_priority_queue");
    end else begin
      $display("FAIL sorted_priority_queue");
    end
    $finish;
  end

endmodule

[sorted_priority_queue.f]
sv/spq_pkg.sv
sv/spq_ctrl.sv
sv/spq_datapath.sv
sv/sorted_priority_queue.sv
tb/spq_checker.sv
tb/testbench.sv
